[sv/lppe_pkg.sv]
// lppe_pkg: shared types and constants of the led pixel pulse encoder
// no dependencies
`default_nettype none

package lppe_pkg;

   localparam int unsigned BITS_PER_PIXEL = 24;
   localparam int unsigned BIT_CNT_W      = 5;
   localparam logic [BIT_CNT_W-1:0] LAST_BIT = 5'd23;
   localparam logic [8:0]  FULL_SCALE     = 9'd256;
   localparam logic [14:0] LOW_MAX        = 15'd32767;
   localparam int unsigned QUEUE_DEPTH    = 2;
   localparam int unsigned QUEUE_PTR_W    = 1;
   localparam int unsigned QUEUE_CNT_W    = 2;
   localparam int unsigned CSR_INDEX_W    = 3;
   localparam int unsigned CSR_DATA_W     = 15;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_BRIGHTNESS  = 3'd0,
      REG_ONE_HIGH    = 3'd1,
      REG_ZERO_HIGH   = 3'd2,
      REG_BIT_PERIOD  = 3'd3,
      REG_RESET_TICKS = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [8:0]  brightness;
      logic [7:0]  one_high_ticks;
      logic [7:0]  zero_high_ticks;
      logic [7:0]  bit_period_ticks;
      logic [14:0] reset_ticks;
   } cfg_type;

   typedef struct packed {
      logic [BITS_PER_PIXEL-1:0] grb_word;
      logic                      end_of_frame;
   } entry_type;

endpackage

`default_nettype wire

[sv/lppe_csr.sv]
// lppe_csr: configuration registers of the pulse encoder
// depends on lppe_pkg
`default_nettype none

module lppe_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [lppe_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [lppe_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output lppe_pkg::cfg_type                        cfg
);

   lppe_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            lppe_pkg::REG_BRIGHTNESS:  cfg_in.brightness       = csr_wdata[8:0];
            lppe_pkg::REG_ONE_HIGH:    cfg_in.one_high_ticks   = csr_wdata[7:0];
            lppe_pkg::REG_ZERO_HIGH:   cfg_in.zero_high_ticks  = csr_wdata[7:0];
            lppe_pkg::REG_BIT_PERIOD:  cfg_in.bit_period_ticks = csr_wdata[7:0];
            lppe_pkg::REG_RESET_TICKS: cfg_in.reset_ticks      = csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.brightness       <= 9'd256;
         cfg_ff.one_high_ticks   <= 8'd32;
         cfg_ff.zero_high_ticks  <= 8'd16;
         cfg_ff.bit_period_ticks <= 8'd50;
         cfg_ff.reset_ticks      <= 15'd2000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[sv/lppe_front.sv]
// lppe_front: accepts pixels, scales channels and reorders them green, red, blue
// depends on lppe_pkg
`default_nettype none

module lppe_front (
   input  wire logic                 req_push,
   output logic                      req_full,
   input  wire logic [23:0]          req_pixel_color,
   input  wire logic                 req_end_of_frame,
   input  wire lppe_pkg::cfg_type    cfg,
   input  wire logic                 q_full,
   output logic                      q_push,
   output lppe_pkg::entry_type       q_entry
);

   logic [8:0]  scale;
   logic [16:0] red_prod;
   logic [16:0] green_prod;
   logic [16:0] blue_prod;

   // brightness above full counts as full
   assign scale = cfg.brightness[8] ? lppe_pkg::FULL_SCALE : cfg.brightness;

   assign red_prod   = {9'd0, req_pixel_color[23:16]} * {8'd0, scale};
   assign green_prod = {9'd0, req_pixel_color[15:8]}  * {8'd0, scale};
   assign blue_prod  = {9'd0, req_pixel_color[7:0]}   * {8'd0, scale};

   assign req_full = q_full;
   assign q_push   = req_push && !q_full;

   assign q_entry.grb_word     = {green_prod[15:8], red_prod[15:8], blue_prod[15:8]};
   assign q_entry.end_of_frame = req_end_of_frame;

endmodule

`default_nettype wire

[sv/lppe_queue.sv]
// lppe_queue: short word queue between front and back
// depends on lppe_pkg
`default_nettype none

module lppe_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire lppe_pkg::entry_type  push_entry,
   output logic                      full,
   input  wire logic                 pop,
   output lppe_pkg::entry_type       pop_entry,
   output logic                      valid
);

   localparam logic [lppe_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
      lppe_pkg::QUEUE_PTR_W'(lppe_pkg::QUEUE_DEPTH - 1);
   localparam logic [lppe_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
      lppe_pkg::QUEUE_CNT_W'(lppe_pkg::QUEUE_DEPTH);

   lppe_pkg::entry_type entries_ff [lppe_pkg::QUEUE_DEPTH];
   logic [lppe_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [lppe_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [lppe_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_FULL);
   assign valid     = (count_ff != '0);
   assign pop_entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_FULL)
      else $error("queue count beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a push");

endmodule

`default_nettype wire

[sv/lppe_back.sv]
// lppe_back: serializes queued words into pulse symbols, one per cycle while rsp_pop keeps up
// depends on lppe_pkg
`default_nettype none

module lppe_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lppe_pkg::cfg_type    cfg,
   input  wire logic                 q_valid,
   input  wire lppe_pkg::entry_type  q_entry,
   output logic                      q_pop,
   output logic                      rsp_empty,
   input  wire logic                 rsp_pop,
   output logic [7:0]                rsp_high_duration,
   output logic [14:0]               rsp_low_duration,
   output logic                      rsp_last_of_pixel,
   output logic                      rsp_frame_done
);

   logic                                  busy_ff, busy_in;
   logic [lppe_pkg::BITS_PER_PIXEL-1:0]   word_ff, word_in;
   logic                                  eof_ff, eof_in;
   logic [lppe_pkg::BIT_CNT_W-1:0]        count_ff, count_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]                            high_ff, high_in;
   logic [14:0]                           low_ff, low_in;
   logic                                  last_ff, last_in;
   logic                                  done_ff, done_in;

   logic        out_free;
   logic        emit;
   logic        last_bit;
   logic [7:0]  high_sel;
   logic [7:0]  low_base;
   logic [15:0] low_sum;

   assign out_free = !rsp_valid_ff || rsp_pop;
   assign emit     = busy_ff && out_free;
   assign last_bit = (count_ff == lppe_pkg::LAST_BIT);
   assign q_pop    = q_valid && (!busy_ff || (emit && last_bit));

   assign high_sel = word_ff[lppe_pkg::BITS_PER_PIXEL-1] ? cfg.one_high_ticks
                                                         : cfg.zero_high_ticks;
   assign low_base = (cfg.bit_period_ticks > high_sel) ? cfg.bit_period_ticks - high_sel
                                                       : 8'd0;
   assign low_sum  = {8'd0, low_base} + {1'b0, cfg.reset_ticks};

   always_comb begin
      busy_in      = busy_ff;
      word_in      = word_ff;
      eof_in       = eof_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      high_in      = high_ff;
      low_in       = low_ff;
      last_in      = last_ff;
      done_in      = done_ff;

      if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
         high_in      = high_sel;
         last_in      = last_bit;
         done_in      = last_bit && eof_ff;
         if (last_bit && eof_ff) begin
            // reset gap, saturating
            low_in = low_sum[15] ? lppe_pkg::LOW_MAX : low_sum[14:0];
         end else begin
            low_in = {7'd0, low_base};
         end
         word_in  = {word_ff[lppe_pkg::BITS_PER_PIXEL-2:0], 1'b0};
         count_in = count_ff + 1'b1;
         if (last_bit) begin
            busy_in = 1'b0;
         end
      end

      if (q_pop) begin
         busy_in  = 1'b1;
         word_in  = q_entry.grb_word;
         eof_in   = q_entry.end_of_frame;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      eof_ff  <= eof_in;
      high_ff <= high_in;
      low_ff  <= low_in;
      last_ff <= last_in;
      done_ff <= done_in;
   end

   assign rsp_empty         = !rsp_valid_ff;
   assign rsp_high_duration = high_ff;
   assign rsp_low_duration  = low_ff;
   assign rsp_last_of_pixel = last_ff;
   assign rsp_frame_done    = done_ff;

   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (count_ff <= lppe_pkg::LAST_BIT))
      else $error("bit counter beyond last bit");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && done_ff) |-> last_ff)
      else $error("frame done off the last symbol of a pixel");

   assert property (@(posedge clock) disable iff (reset)
      (emit && last_bit) |=> (rsp_valid_ff && last_ff))
      else $error("last symbol of a pixel not presented");

endmodule

`default_nettype wire

[sv/led_pixel_pulse_encoder.sv]
// led_pixel_pulse_encoder: top level of the led pixel pulse encoder
// depends on lppe_pkg, lppe_csr, lppe_front, lppe_queue, lppe_back
//
// Each pixel written on the req_ queue becomes 24 pulse symbols on the rsp_ queue,
// green, red, blue, msb first, one symbol per clock while rsp_pop keeps up; the
// symbol serializer in the back end sets that rate. A two-word queue after the
// brightness scaling lets the next pixel be taken while the current one is still
// being sent. A pushed pixel passes the queue and the back end's word register
// before its first symbol is registered on the rsp_ outputs. csr_ writes are always
// taken; write them only while no pixel is in flight.
`default_nettype none

module led_pixel_pulse_encoder (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_push,
   output logic                                     req_full,
   input  wire logic [23:0]                         req_pixel_color,
   input  wire logic                                req_end_of_frame,
   output logic                                     rsp_empty,
   input  wire logic                                rsp_pop,
   output logic [7:0]                               rsp_high_duration,
   output logic [14:0]                              rsp_low_duration,
   output logic                                     rsp_last_of_pixel,
   output logic                                     rsp_frame_done,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [lppe_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [lppe_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   lppe_pkg::cfg_type   cfg;
   lppe_pkg::entry_type push_entry;
   lppe_pkg::entry_type pop_entry;
   logic                q_push;
   logic                q_full;
   logic                q_pop;
   logic                q_valid;

   lppe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lppe_front u_front (
      .req_push         (req_push),
      .req_full         (req_full),
      .req_pixel_color  (req_pixel_color),
      .req_end_of_frame (req_end_of_frame),
      .cfg              (cfg),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_entry          (push_entry)
   );

   lppe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .valid      (q_valid)
   );

   lppe_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .q_valid           (q_valid),
      .q_entry           (pop_entry),
      .q_pop             (q_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_high_duration (rsp_high_duration),
      .rsp_low_duration  (rsp_low_duration),
      .rsp_last_of_pixel (rsp_last_of_pixel),
      .rsp_frame_done    (rsp_frame_done)
   );

endmodule

`default_nettype wire
